// File: rtl/edfdt_pkg.sv
package edfdt_pkg;

    localparam logic [7:0]  DOT_CHAR      = 8'h2E;
    localparam logic [6:0]  PIVOT_YEAR    = 7'd85;
    localparam logic [6:0]  YEARS_PRE_1985 = 7'd15;
    localparam logic [15:0] DAYS_TO_1985  = 16'd5479;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
    localparam logic [41:0] EPOCH_MS_MIN  = 42'd473385600000;
    localparam logic [41:0] EPOCH_MS_MAX  = 42'd3629145599000;

    typedef struct packed {
        logic       fmt_ok;
        logic [6:0] day;
        logic [6:0] mon;
        logic [6:0] yr2;
        logic [6:0] hr;
        logic [6:0] mi;
        logic [6:0] se;
    } edfdt_fields_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd2:                        n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:          n = 5'd31;
            default:                     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/edfdt_parse.sv
module edfdt_parse
    import edfdt_pkg::*;
(
    input  logic [63:0]   date_text,
    input  logic [63:0]   time_text,
    output edfdt_fields_t fields
);

    logic [7:0] dch [8];
    logic [7:0] tch [8];
    logic [7:0] dgt_ok;
    logic [7:0] tgt_ok;
    logic [3:0] dv [8];
    logic [3:0] tv [8];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            dch[i]    = date_text[63 - 8 * i -: 8];
            tch[i]    = time_text[63 - 8 * i -: 8];
            dgt_ok[i] = (dch[i][7:4] == 4'h3) && (dch[i][3:0] <= 4'd9);
            tgt_ok[i] = (tch[i][7:4] == 4'h3) && (tch[i][3:0] <= 4'd9);
            dv[i]     = dch[i][3:0];
            tv[i]     = tch[i][3:0];
        end
    end

    function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
        return 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
    endfunction

    always_comb begin
        fields.fmt_ok = (dch[2] == DOT_CHAR) && (dch[5] == DOT_CHAR)
                     && (tch[2] == DOT_CHAR) && (tch[5] == DOT_CHAR)
                     && dgt_ok[0] && dgt_ok[1] && dgt_ok[3] && dgt_ok[4]
                     && dgt_ok[6] && dgt_ok[7]
                     && tgt_ok[0] && tgt_ok[1] && tgt_ok[3] && tgt_ok[4]
                     && tgt_ok[6] && tgt_ok[7];
        fields.day = pair(dv[0], dv[1]);
        fields.mon = pair(dv[3], dv[4]);
        fields.yr2 = pair(dv[6], dv[7]);
        fields.hr  = pair(tv[0], tv[1]);
        fields.mi  = pair(tv[3], tv[4]);
        fields.se  = pair(tv[6], tv[7]);
    end

endmodule

// File: rtl/edf_start_date_time_to_ms.sv
// Converts the start date "dd.mm.yy" and start time "hh.mm.ss" of an EDF header into
// milliseconds since 1970-01-01 00:00:00 UTC, with a flag that is high when both fields are
// well formed and in range (years 85..99 are 1985..1999, 00..84 are 2000..2084). One word
// enters per clock cycle unless back-pressure holds it, and passes through a four-stage pipeline
// (character check, calendar day count, seconds, milliseconds); every stage holds its word on
// its own under back-pressure, so bubbles are squeezed out. An invalid word gives zero.
module edf_start_date_time_to_ms
    import edfdt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // date_text[63:0], time_text[127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // epoch_ms[41:0], zero padding[47:42]
    output logic         m_tuser    // valid_res
);

    edfdt_fields_t fields_next;
    edfdt_fields_t f1_reg;
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          rdy1, rdy2, rdy3, rdy4;

    logic          ok2_next, ok2_reg, ok3_reg;
    logic [15:0]   days_next, days_reg;
    logic [16:0]   sod_next, sod_reg;
    logic [31:0]   sec_next, sec_reg;
    logic [41:0]   ms_next, ms_reg;
    logic          res_ok_reg;

    logic [6:0]    k_yr;
    logic          leap;
    logic [4:0]    mdays;
    logic [9:0]    doy;

    edfdt_parse u_parse (
        .date_text (s_tdata[63:0]),
        .time_text (s_tdata[127:64]),
        .fields    (fields_next)
    );

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_comb begin
        k_yr  = (f1_reg.yr2 >= PIVOT_YEAR) ? (f1_reg.yr2 - PIVOT_YEAR)
                                           : (f1_reg.yr2 + YEARS_PRE_1985);
        leap  = (k_yr[1:0] == 2'b11);
        mdays = month_len(f1_reg.mon[3:0], leap);
        ok2_next = f1_reg.fmt_ok
                && (f1_reg.mon >= 7'd1) && (f1_reg.mon <= 7'd12)
                && (f1_reg.day >= 7'd1) && (f1_reg.day <= 7'(mdays))
                && (f1_reg.hr <= 7'd23) && (f1_reg.mi <= 7'd59) && (f1_reg.se <= 7'd59);
        doy = 10'(days_before_month(f1_reg.mon[3:0]))
            + 10'(leap && (f1_reg.mon > 7'd2))
            + 10'(f1_reg.day) - 10'd1;
        days_next = DAYS_TO_1985 + 16'(16'(k_yr) * 16'(DAYS_PER_YEAR)) + 16'(k_yr >> 2)
                  + 16'(doy);
        sod_next  = 17'(17'(f1_reg.hr) * 17'(SEC_PER_HOUR))
                  + 17'(17'(f1_reg.mi) * 17'(SEC_PER_MIN))
                  + 17'(f1_reg.se);
    end

    assign sec_next = 32'(32'(days_reg) * 32'(SEC_PER_DAY)) + 32'(sod_reg);
    assign ms_next  = ok3_reg ? 42'(42'(sec_reg) * 42'(MS_PER_SEC)) : 42'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            f1_reg <= fields_next;
        end
        if (rdy2) begin
            ok2_reg  <= ok2_next;
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
        if (rdy3) begin
            ok3_reg <= ok2_reg;
            sec_reg <= sec_next;
        end
        if (rdy4) begin
            res_ok_reg <= ok3_reg;
            ms_reg     <= ms_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tuser  = res_ok_reg;
    assign m_tdata  = {6'd0, ms_reg};

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 48'd0))
        else $error("invalid word carries a nonzero time");

    a_valid_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[41:0] >= EPOCH_MS_MIN)
                                  && (m_tdata[41:0] <= EPOCH_MS_MAX)))
        else $error("valid time outside the accepted date range");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> s_tready)
        else $error("empty pipeline refuses input");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

// File: sim/edf_stamp_checker.sv
module edf_stamp_checker
    import edfdt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           outstanding
);

    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] NINE_CHAR = 8'h39;

    typedef struct packed {
        logic        ok;
        logic [41:0] ms;
    } stamp_t;

    typedef struct {
        logic [127:0] word;
        stamp_t       want;
    } order_t;

    order_t expected_stamps[$];

    function automatic bit is_leap_year(input int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic int days_in_month(input int y, input int m);
        case (m)
            2:             return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic stamp_t decode_stamp(input logic [63:0] dtext, input logic [63:0] ttext);
        stamp_t           r;
        logic [7:0]       dc [8];
        logic [7:0]       tc [8];
        bit               fmt;
        int               dd, mo, yy, hh, mi, ss, year, days;
        longint unsigned  ms;
        r = '0;
        fmt = 1'b1;
        for (int i = 0; i < 8; i++) begin
            dc[i] = dtext[63 - 8 * i -: 8];
            tc[i] = ttext[63 - 8 * i -: 8];
            if (i == 2 || i == 5) begin
                fmt &= (dc[i] == DOT_CHAR) && (tc[i] == DOT_CHAR);
            end else begin
                fmt &= (dc[i] >= ZERO_CHAR) && (dc[i] <= NINE_CHAR);
                fmt &= (tc[i] >= ZERO_CHAR) && (tc[i] <= NINE_CHAR);
            end
        end
        if (!fmt) begin
            return r;
        end
        dd = int'(dc[0] - ZERO_CHAR) * 10 + int'(dc[1] - ZERO_CHAR);
        mo = int'(dc[3] - ZERO_CHAR) * 10 + int'(dc[4] - ZERO_CHAR);
        yy = int'(dc[6] - ZERO_CHAR) * 10 + int'(dc[7] - ZERO_CHAR);
        hh = int'(tc[0] - ZERO_CHAR) * 10 + int'(tc[1] - ZERO_CHAR);
        mi = int'(tc[3] - ZERO_CHAR) * 10 + int'(tc[4] - ZERO_CHAR);
        ss = int'(tc[6] - ZERO_CHAR) * 10 + int'(tc[7] - ZERO_CHAR);
        year = (yy >= 85) ? 1900 + yy : 2000 + yy;
        if (mo < 1 || mo > 12 || dd < 1 || dd > days_in_month(year, mo)) begin
            return r;
        end
        if (hh > 23 || mi > 59 || ss > 59) begin
            return r;
        end
        days = 0;
        for (int y = 1970; y < year; y++) begin
            days += is_leap_year(y) ? 366 : 365;
        end
        for (int m = 1; m < mo; m++) begin
            days += days_in_month(year, m);
        end
        days += dd - 1;
        ms = (longint'(days) * 86400 + hh * 3600 + mi * 60 + ss) * 1000;
        r.ok = 1'b1;
        r.ms = ms[41:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        order_t e;
        if (!aresetn) begin
            fail_count = 0;
            outstanding = 0;
            expected_stamps.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_stamps.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected: %h/%b",
                                              m_tdata, m_tuser));
                end else begin
                    e = expected_stamps.pop_front();
                    if (m_tuser !== e.want.ok) begin
                        report_mismatch($sformatf("valid_res %b, want %b for %h",
                                                  m_tuser, e.want.ok, e.word));
                    end
                    if (m_tdata[41:0] !== e.want.ms) begin
                        report_mismatch($sformatf("epoch_ms %0d, want %0d for %h",
                                                  m_tdata[41:0], e.want.ms, e.word));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                e.word = s_tdata;
                e.want = decode_stamp(s_tdata[63:0], s_tdata[127:64]);
                expected_stamps.push_back(e);
            end
            outstanding = expected_stamps.size();
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    import edfdt_pkg::*;

    localparam int         RANDOM_WORDS = 900;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [7:0] ZERO_CHAR    = 8'h30;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           outstanding;
    int           cycles   = 0;
    bit           no_idle  = 1'b0;
    int           stall_left = 0;

    edf_start_date_time_to_ms dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    edf_stamp_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 4);
    endfunction

    // Result side: mostly ready, with short and occasional long stalls.
    always @(posedge aclk) begin
        if (aresetn && stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = idle_len();
        end
        m_tready <= aresetn && (stall_left == 0);
        if (stall_left > 0) begin
            stall_left--;
        end
    end

    function automatic logic [63:0] pack_text(input int a, input int b, input int c);
        return {ZERO_CHAR + 8'(a / 10), ZERO_CHAR + 8'(a % 10), DOT_CHAR,
                ZERO_CHAR + 8'(b / 10), ZERO_CHAR + 8'(b % 10), DOT_CHAR,
                ZERO_CHAR + 8'(c / 10), ZERO_CHAR + 8'(c % 10)};
    endfunction

    task automatic send_word(input logic [63:0] date_text, input logic [63:0] time_text);
        int gap;
        gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {time_text, date_text};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(input int dd, input int mo, input int yy,
                               input int hh, input int mi, input int ss);
        send_word(pack_text(dd, mo, yy), pack_text(hh, mi, ss));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic random_stamp(output logic [63:0] date_text, output logic [63:0] time_text);
        int kind, mo, top_day, pos;
        kind = $urandom_range(0, 99);
        mo = $urandom_range(1, 12);
        top_day = (mo == 2) ? 29 : (mo == 4 || mo == 6 || mo == 9 || mo == 11) ? 30 : 31;
        date_text = pack_text($urandom_range(1, top_day), mo, $urandom_range(0, 99));
        time_text = pack_text($urandom_range(0, 23), $urandom_range(0, 59),
                              $urandom_range(0, 59));
        if (kind >= 55 && kind < 75) begin
            date_text = pack_text($urandom_range(0, 99), $urandom_range(0, 99),
                                  $urandom_range(0, 99));
            time_text = pack_text($urandom_range(0, 99), $urandom_range(0, 99),
                                  $urandom_range(0, 99));
        end else if (kind >= 75 && kind < 90) begin
            pos = $urandom_range(0, 7);
            if ($urandom_range(0, 1) == 0) begin
                date_text[63 - 8 * pos -: 8] = 8'($urandom);
            end else begin
                time_text[63 - 8 * pos -: 8] = 8'($urandom);
            end
        end else if (kind >= 90) begin
            date_text = {$urandom, $urandom};
            time_text = {$urandom, $urandom};
        end
    endtask

    initial begin
        logic [63:0] date_text, time_text;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_fields(1, 1, 85, 0, 0, 0);
        send_fields(31, 12, 84, 23, 59, 59);
        send_fields(31, 12, 99, 23, 59, 59);
        send_fields(1, 1, 0, 0, 0, 0);
        send_fields(29, 2, 0, 12, 30, 30);
        send_fields(29, 2, 1, 12, 30, 30);
        send_fields(29, 2, 88, 6, 7, 8);
        send_fields(29, 2, 84, 6, 7, 8);
        send_fields(28, 2, 99, 1, 2, 3);
        send_fields(0, 1, 90, 0, 0, 0);
        send_fields(1, 0, 90, 0, 0, 0);
        send_fields(1, 13, 90, 0, 0, 0);
        send_fields(32, 1, 90, 0, 0, 0);
        send_fields(31, 4, 90, 0, 0, 0);
        send_fields(30, 4, 90, 0, 0, 0);
        send_fields(15, 6, 95, 24, 0, 0);
        send_fields(15, 6, 95, 23, 60, 0);
        send_fields(15, 6, 95, 23, 59, 60);
        send_fields(99, 99, 99, 99, 99, 99);
        send_word(pack_text(1, 1, 90), "12:00:00");
        send_word(" 1.01.90", pack_text(0, 0, 0));
        send_word(pack_text(1, 1, 90), {8'h31, 8'h32, DOT_CHAR, 40'h3030_2E30_00});
        send_word(64'h0, 64'h0);
        send_word({64{1'b1}}, {64{1'b1}});

        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 300 && n < 420);
            if (n == 600) begin
                drain_results();
            end
            random_stamp(date_text, time_text);
            send_word(date_text, time_text);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/edfdt_pkg.sv
rtl/edfdt_parse.sv
rtl/edf_start_date_time_to_ms.sv
sim/edf_stamp_checker.sv
sim/tb_top.sv
